>>> hw/rtl/stfw_pkg.sv
package stfw_pkg;

   // default table shape
   localparam int NUM_SEMS_DEF  = 16;
   localparam int NUM_PROCS_DEF = 16;

   // field widths
   localparam int KIND_W     = 2;
   localparam int SEM_IDX_W  = 4;
   localparam int COUNT_W    = 16;
   localparam int PID_W      = 4;
   localparam int ALLOC_IDX_W = 4;

   // packed stream widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // count saturation limits
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;
   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7fff;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC  = 2'd0,
      KIND_WAIT   = 2'd1,
      KIND_SIGNAL = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_RESOLVE
   } state_type;

   typedef struct packed {
      logic clear;   // write one clearing entry
      logic accept;  // capture request, read table entry
      logic lookup;  // read wait ring slot
      logic commit;  // write back, load response
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } sts_type;

endpackage

>>> hw/rtl/stfw_ram.sv
module stfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/stfw_ctrl.sv
module stfw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output stfw_pkg::cmd_type  cmd,
   input  stfw_pkg::sts_type  sts
);

   stfw_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stfw_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         stfw_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = stfw_pkg::ST_IDLE;
            end
         end
         stfw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = stfw_pkg::ST_LOOKUP;
            end
         end
         stfw_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = stfw_pkg::ST_RESOLVE;
         end
         stfw_pkg::ST_RESOLVE: begin
            // hold until the response register can take the result
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = stfw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stfw_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_accept_then_lookup: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == stfw_pkg::ST_LOOKUP)
      else $error("accepted request not followed by table lookup");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == stfw_pkg::ST_CLEAR |-> !req_tready)
      else $error("request taken during clearing pass");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_valid_ff || rsp_tready)
      else $error("commit would overwrite a pending response");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise response valid");

endmodule

>>> hw/rtl/stfw_dp.sv
module stfw_dp #(
   parameter int NUM_SEMS  = stfw_pkg::NUM_SEMS_DEF,
   parameter int NUM_PROCS = stfw_pkg::NUM_PROCS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  stfw_pkg::cmd_type                 cmd,
   output stfw_pkg::sts_type                 sts,
   input  logic [stfw_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [stfw_pkg::KIND_W-1:0]       req_tuser,
   output logic [stfw_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int SEM_AW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int SEM_CW  = $clog2(NUM_SEMS + 1);
   localparam int PROC_AW = $clog2(NUM_PROCS);
   localparam int Q_DEPTH = NUM_SEMS * NUM_PROCS;
   localparam int QAW     = $clog2(Q_DEPTH);
   localparam int CW      = stfw_pkg::COUNT_W;
   localparam int PW      = stfw_pkg::PID_W;
   localparam int TW      = CW + 2 * PROC_AW;
   localparam int QW      = 1 + PW;

   // ring position after p
   function automatic logic [PROC_AW-1:0] next_slot(input logic [PROC_AW-1:0] p);
      logic [PROC_AW-1:0] r;
      if (32'(p) == NUM_PROCS - 1) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // flat address of a ring slot
   function automatic logic [QAW-1:0] q_addr(input logic [SEM_AW-1:0] s,
                                             input logic [PROC_AW-1:0] slot);
      logic [QAW-1:0] a;
      a = QAW'(QAW'(s) * QAW'(NUM_PROCS)) + QAW'(slot);
      return a;
   endfunction

   // captured request
   logic [stfw_pkg::KIND_W-1:0]    kind_ff;
   logic [stfw_pkg::SEM_IDX_W-1:0] sem_ff;
   logic signed [CW-1:0]           init_ff;
   logic [PW-1:0]                  pid_ff;
   logic [SEM_AW-1:0]              tbl_addr_ff;

   logic [SEM_CW-1:0] alloc_cnt_ff, alloc_cnt_in;
   logic [QAW-1:0]    clr_addr_ff;
   logic [stfw_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memory ports
   logic              tbl_we;
   logic [SEM_AW-1:0] tbl_waddr, tbl_raddr;
   logic [TW-1:0]     tbl_wdata, tbl_rdata;
   logic              q_we;
   logic [QAW-1:0]    q_waddr, q_raddr;
   logic [QW-1:0]     q_wdata, q_rdata;

   // decoded table entry
   logic signed [CW-1:0] t_count, cnt_dec, cnt_inc;
   logic [PROC_AW-1:0]   t_head, t_tail, head_next, tail_next;
   logic                 in_range, alloc_ok;

   // result fields
   logic [stfw_pkg::ALLOC_IDX_W-1:0] res_idx;
   logic                             res_fail, res_blocks, res_woke;
   logic [PW-1:0]                    res_wpid;

   stfw_ram #(.WIDTH(TW), .DEPTH(NUM_SEMS)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   stfw_ram #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_ring_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (cmd.lookup),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   assign t_count   = signed'(tbl_rdata[TW-1 -: CW]);
   assign t_head    = tbl_rdata[2*PROC_AW-1 -: PROC_AW];
   assign t_tail    = tbl_rdata[PROC_AW-1:0];
   assign head_next = next_slot(t_head);
   assign tail_next = next_slot(t_tail);
   assign cnt_dec   = (t_count != stfw_pkg::COUNT_MIN) ? t_count - 16'sd1 : t_count;
   assign cnt_inc   = (t_count != stfw_pkg::COUNT_MAX) ? t_count + 16'sd1 : t_count;
   assign in_range  = 32'(sem_ff) < NUM_SEMS;
   assign alloc_ok  = 32'(alloc_cnt_ff) < NUM_SEMS;

   // allocate reads the next free entry, others the addressed one
   assign tbl_raddr = (req_tuser == stfw_pkg::KIND_ALLOC) ?
                      alloc_cnt_ff[SEM_AW-1:0] :
                      SEM_AW'(req_tdata[stfw_pkg::SEM_IDX_W-1:0]);
   assign q_raddr   = q_addr(tbl_addr_ff, head_next);

   always_comb begin
      tbl_we       = 1'b0;
      tbl_waddr    = tbl_addr_ff;
      tbl_wdata    = {t_count, t_head, t_tail};
      q_we         = 1'b0;
      q_waddr      = q_addr(tbl_addr_ff, t_tail);
      q_wdata      = '0;
      alloc_cnt_in = alloc_cnt_ff;
      res_idx      = '0;
      res_fail     = 1'b0;
      res_blocks   = 1'b0;
      res_woke     = 1'b0;
      res_wpid     = '0;
      if (cmd.clear) begin
         tbl_we    = 32'(clr_addr_ff) < NUM_SEMS;
         tbl_waddr = clr_addr_ff[SEM_AW-1:0];
         tbl_wdata = {{CW{1'b0}}, PROC_AW'(NUM_PROCS - 1), {PROC_AW{1'b0}}};
         q_we      = 1'b1;
         q_waddr   = clr_addr_ff;
      end else if (cmd.commit) begin
         case (kind_ff)
            stfw_pkg::KIND_ALLOC: begin
               if (alloc_ok) begin
                  tbl_we       = 1'b1;
                  tbl_wdata    = {init_ff, t_head, t_tail};
                  res_idx      = stfw_pkg::ALLOC_IDX_W'(alloc_cnt_ff);
                  alloc_cnt_in = alloc_cnt_ff + 1'b1;
               end else begin
                  res_fail = 1'b1;
               end
            end
            stfw_pkg::KIND_WAIT: begin
               if (in_range) begin
                  tbl_we = 1'b1;
                  if (cnt_dec < 0) begin
                     // enqueue at tail, overwriting whatever sits there
                     q_we       = 1'b1;
                     q_wdata    = {1'b1, pid_ff};
                     tbl_wdata  = {cnt_dec, t_head, tail_next};
                     res_blocks = 1'b1;
                  end else begin
                     tbl_wdata = {cnt_dec, t_head, t_tail};
                  end
               end
            end
            stfw_pkg::KIND_SIGNAL: begin
               if (in_range) begin
                  tbl_we = 1'b1;
                  if (q_rdata[PW]) begin
                     q_we      = 1'b1;
                     q_waddr   = q_addr(tbl_addr_ff, head_next);
                     q_wdata   = {1'b0, q_rdata[PW-1:0]};
                     tbl_wdata = {cnt_inc, head_next, t_tail};
                     res_woke  = 1'b1;
                     res_wpid  = q_rdata[PW-1:0];
                  end else begin
                     tbl_wdata = {cnt_inc, t_head, t_tail};
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_data_in = {5'b0, res_wpid, res_woke, res_blocks, res_fail, res_idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_cnt_ff <= '0;
         clr_addr_ff  <= '0;
      end else begin
         alloc_cnt_ff <= alloc_cnt_in;
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff     <= req_tuser;
         sem_ff      <= req_tdata[3:0];
         init_ff     <= signed'(req_tdata[19:4]);
         pid_ff      <= req_tdata[23:20];
         tbl_addr_ff <= tbl_raddr;
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign sts.clear_last = clr_addr_ff == QAW'(Q_DEPTH - 1);
   assign rsp_tdata      = rsp_data_ff;

endmodule

>>> hw/rtl/semaphore_table_fifo_wait_unit.sv
// counting semaphore table with a fifo wait ring per entry
//
// request stream (req_*): tuser carries the call kind (allocate, wait,
// signal), tdata the entry index, initial count and caller id. every
// request gives exactly one response on the rsp_* stream, in order.
// response tdata: allocated index, allocate failure, caller blocks,
// woke flag and woken process id.
//
// timing: the table read, the ring read and the write-back run as one
// shared sequence over the two memories, so a new request is taken only
// after the previous one has been written back.
// the next request is taken while a response still waits, so a stalled
// receiver costs nothing until a second result is ready; the unit then
// holds that result internally and takes no request until rsp_tready.
//
// after reset a clearing pass over all NUM_SEMS * NUM_PROCS ring slots
// (256 by default) empties every ring and zeroes every count; req_tready
// stays low meanwhile.
module semaphore_table_fifo_wait_unit #(
   parameter int NUM_SEMS  = stfw_pkg::NUM_SEMS_DEF,
   parameter int NUM_PROCS = stfw_pkg::NUM_PROCS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sem_index[3:0], init_value[19:4], caller_pid[23:20]
   input  logic [stfw_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [stfw_pkg::KIND_W-1:0]     req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // alloc_index[3:0], alloc_failed[4], caller_blocks[5], woke[6],
   // woken_pid[10:7], zero fill[15:11]
   output logic [stfw_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   stfw_pkg::cmd_type cmd;
   stfw_pkg::sts_type sts;

   // sequencing: clear pass, accept, lookup, resolve and write-back
   stfw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // table and ring memories, count update, response register
   stfw_dp #(
      .NUM_SEMS  (NUM_SEMS),
      .NUM_PROCS (NUM_PROCS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> tb/semaphore_call_checker.sv
`timescale 1ns / 1ps

module semaphore_call_checker #(
   parameter int NUM_SEMS  = stfw_pkg::NUM_SEMS_DEF,
   parameter int NUM_PROCS = stfw_pkg::NUM_PROCS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // sem_index[3:0], init_value[19:4], caller_pid[23:20]
   input  logic [stfw_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [stfw_pkg::KIND_W-1:0]     req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // alloc_index[3:0], alloc_failed[4], caller_blocks[5], woke[6],
   // woken_pid[10:7], zero fill[15:11]
   input  logic [stfw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              failures,
   output int                              pending,
   output int                              n_checked,
   output int                              n_granted,
   output int                              n_alloc_fail,
   output int                              n_blocked,
   output int                              n_woken,
   output int                              n_overwrite
);

   typedef struct packed {
      logic [stfw_pkg::PID_W-1:0]       woken_pid;
      logic                             woke;
      logic                             caller_blocks;
      logic                             alloc_failed;
      logic [stfw_pkg::ALLOC_IDX_W-1:0] alloc_index;
   } reply_type;

   // shadow of the semaphore table and its wait rings
   bit                                  in_use    [NUM_SEMS];
   logic signed [stfw_pkg::COUNT_W-1:0] sem_count [NUM_SEMS];
   logic [stfw_pkg::PID_W-1:0]          ring_pid  [NUM_SEMS][NUM_PROCS];
   bit                                  ring_full [NUM_SEMS][NUM_PROCS];
   int unsigned                         ring_head [NUM_SEMS];
   int unsigned                         ring_tail [NUM_SEMS];

   reply_type expected_replies [$];

   task automatic apply_call(input logic [stfw_pkg::KIND_W-1:0] k,
                             input logic [stfw_pkg::REQ_DATA_W-1:0] d,
                             output reply_type r);
      logic [stfw_pkg::SEM_IDX_W-1:0]      s;
      logic signed [stfw_pkg::COUNT_W-1:0] init;
      logic [stfw_pkg::PID_W-1:0]          pid;
      int unsigned                         slot;
      bit                                  found;
      s = d[3:0];
      init = d[19:4];
      pid = d[23:20];
      r = '0;
      found = 0;
      case (k)
         stfw_pkg::KIND_ALLOC: begin
            for (int i = 0; i < NUM_SEMS; i++) begin
               if (!found && !in_use[i]) begin
                  found = 1;
                  in_use[i] = 1;
                  sem_count[i] = init;
                  r.alloc_index = stfw_pkg::ALLOC_IDX_W'(i);
                  n_granted++;
               end
            end
            if (!found) begin
               r.alloc_failed = 1'b1;
               n_alloc_fail++;
            end
         end
         stfw_pkg::KIND_WAIT: if (s < NUM_SEMS) begin
            if (sem_count[s] != stfw_pkg::COUNT_MIN) begin
               sem_count[s] = sem_count[s] - 16'sd1;
            end
            if (sem_count[s] < 0) begin
               slot = ring_tail[s];
               if (ring_full[s][slot]) n_overwrite++;
               ring_pid[s][slot] = pid;
               ring_full[s][slot] = 1;
               ring_tail[s] = (slot + 1) % NUM_PROCS;
               r.caller_blocks = 1'b1;
               n_blocked++;
            end
         end
         stfw_pkg::KIND_SIGNAL: if (s < NUM_SEMS) begin
            if (sem_count[s] != stfw_pkg::COUNT_MAX) begin
               sem_count[s] = sem_count[s] + 16'sd1;
            end
            slot = (ring_head[s] + 1) % NUM_PROCS;
            if (ring_full[s][slot]) begin
               r.woken_pid = ring_pid[s][slot];
               r.woke = 1'b1;
               ring_head[s] = slot;
               ring_full[s][slot] = 0;
               n_woken++;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      reply_type made, want;
      if (reset) begin
         for (int s = 0; s < NUM_SEMS; s++) begin
            in_use[s] = 0;
            sem_count[s] = '0;
            ring_head[s] = NUM_PROCS - 1;
            ring_tail[s] = 0;
            for (int p = 0; p < NUM_PROCS; p++) begin
               ring_pid[s][p] = '0;
               ring_full[s][p] = 0;
            end
         end
         expected_replies.delete();
         failures = 0;
         pending = 0;
         n_checked = 0;
         n_granted = 0;
         n_alloc_fail = 0;
         n_blocked = 0;
         n_woken = 0;
         n_overwrite = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_call(req_tuser, req_tdata, made);
            expected_replies.push_back(made);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               $error("response %h with no request outstanding", rsp_tdata);
               failures++;
            end else begin
               want = expected_replies.pop_front();
               n_checked++;
               check_field("alloc_index", want.alloc_index, rsp_tdata[3:0]);
               check_field("alloc_failed", want.alloc_failed, rsp_tdata[4]);
               check_field("caller_blocks", want.caller_blocks, rsp_tdata[5]);
               check_field("woke", want.woke, rsp_tdata[6]);
               check_field("woken_pid", want.woken_pid, rsp_tdata[10:7]);
               check_field("zero fill", 0, rsp_tdata[15:11]);
            end
         end
         pending = expected_replies.size();
      end
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

   // the unused fourth call code: no effect, all-zero response
   localparam logic [stfw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
   localparam int PHASE_CALLS  = 333;  // random requests per idling phase

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [stfw_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [stfw_pkg::KIND_W-1:0]     req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [stfw_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int failures, pending, n_checked, n_granted, n_alloc_fail;
   int n_blocked, n_woken, n_overwrite;

   // idling knobs, in percent, changed per phase
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;

   // hold-off handshake between stimulus and receiver: a bump of
   // hold_gen asks the receiver for one long stretch of tready low
   int hold_gen = 0;
   int hold_seen = 0;
   int hold_left = 0;

   semaphore_table_fifo_wait_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   semaphore_call_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .failures     (failures),
      .pending      (pending),
      .n_checked    (n_checked),
      .n_granted    (n_granted),
      .n_alloc_fail (n_alloc_fail),
      .n_blocked    (n_blocked),
      .n_woken      (n_woken),
      .n_overwrite  (n_overwrite)
   );

   always #4 clock = ~clock;

   // hard stop, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

   // receiver: random stalls, plus a counted hold-off when asked
   always @(negedge clock) begin
      if (hold_gen != hold_seen) begin
         hold_seen = hold_gen;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // offer one request at a falling edge, return at the falling edge
   // after it was taken; valid stays high unless a gap follows
   task automatic issue_call(input logic [stfw_pkg::KIND_W-1:0] k, input logic [3:0] sem,
                             input logic [15:0] init, input logic [3:0] pid);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= {pid, init, sem};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // sender pause until every response is back
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // random request: mostly wait/signal on a few hot entries so the rings
   // fill, wrap and overflow; some allocates and some unused codes
   task automatic random_call(input int wait_pct);
      int                          r;
      logic [stfw_pkg::KIND_W-1:0] k;
      logic [3:0]                  sem;
      logic [15:0]                 init;
      r = $urandom_range(99);
      sem = ($urandom_range(99) < 60) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
      init = 16'($urandom);
      if (r < 8) begin
         k = stfw_pkg::KIND_ALLOC;
         // small counts keep waits and signals crossing zero
         if ($urandom_range(1) == 1) init = 16'($urandom_range(8)) - 16'd4;
      end else if (r < 12) begin
         k = KIND_UNUSED;
      end else if ($urandom_range(99) < wait_pct) begin
         k = stfw_pkg::KIND_WAIT;
      end else begin
         k = stfw_pkg::KIND_SIGNAL;
      end
      issue_call(k, sem, init, 4'($urandom_range(15)));
   endtask

   initial begin
      int wait_pct;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: untouched entry used without allocate
      issue_call(stfw_pkg::KIND_WAIT, 4'd15, 16'($urandom), 4'hf);    // count -1, blocks
      issue_call(stfw_pkg::KIND_SIGNAL, 4'd15, 16'($urandom), 4'h0);  // wakes id 15
      issue_call(stfw_pkg::KIND_SIGNAL, 4'd15, 16'($urandom), 4'h0);  // empty ring
      // unused code, all ones and all zeros
      issue_call(KIND_UNUSED, 4'hf, 16'hffff, 4'hf);
      issue_call(KIND_UNUSED, 4'h0, 16'h0000, 4'h0);
      // allocates at the count extremes
      issue_call(stfw_pkg::KIND_ALLOC, 4'($urandom), 16'h7fff, 4'($urandom));  // entry 0
      issue_call(stfw_pkg::KIND_ALLOC, 4'($urandom), 16'h8000, 4'($urandom));  // entry 1
      issue_call(stfw_pkg::KIND_ALLOC, 4'($urandom), 16'h0000, 4'($urandom));  // entry 2
      issue_call(stfw_pkg::KIND_ALLOC, 4'($urandom), 16'hffff, 4'($urandom));  // entry 3
      // saturation at both limits
      issue_call(stfw_pkg::KIND_SIGNAL, 4'd0, 16'($urandom), 4'h0);
      issue_call(stfw_pkg::KIND_WAIT, 4'd1, 16'($urandom), 4'h0);     // stuck at min, queues
      issue_call(stfw_pkg::KIND_WAIT, 4'd1, 16'($urandom), 4'h9);
      issue_call(stfw_pkg::KIND_SIGNAL, 4'd1, 16'($urandom), 4'h0);   // wakes id 0
      // blocking and waking in order
      issue_call(stfw_pkg::KIND_WAIT, 4'd2, 16'($urandom), 4'h5);
      issue_call(stfw_pkg::KIND_WAIT, 4'd3, 16'($urandom), 4'ha);
      issue_call(stfw_pkg::KIND_SIGNAL, 4'd3, 16'($urandom), 4'h0);
      issue_call(stfw_pkg::KIND_SIGNAL, 4'd2, 16'($urandom), 4'h0);
      issue_call(stfw_pkg::KIND_WAIT, 4'd0, 16'($urandom), 4'h1);     // large count, no block
      drain_replies();

      // random phases: no idling, sender idle, receiver stalling, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  wait_pct = 50; end
            1: begin tx_idle_pct = 74; rx_stall_pct = 0;  wait_pct = 70; end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 74; wait_pct = 40; end
            default: begin tx_idle_pct = 23; rx_stall_pct = 23; wait_pct = 55; end
         endcase
         // long hold-off while requests keep coming, so the unit backs up
         if (ph == 0 || ph == 2) hold_gen++;
         for (int n = 0; n < PHASE_CALLS; n++) random_call(wait_pct);
         drain_replies();
      end

      // quiet tail catches any stray response
      repeat (8) @(negedge clock);
      $display("covered %0d checked responses: %0d allocates granted, %0d refused on a full table",
               n_checked, n_granted, n_alloc_fail);
      $display("%0d callers blocked, %0d woken, %0d full ring slots overwritten",
               n_blocked, n_woken, n_overwrite);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
